[rtl/message_template_hasher_defines.svh]
// assertion macros for the message template hasher
`ifndef MESSAGE_TEMPLATE_HASHER_DEFINES_SVH
`define MESSAGE_TEMPLATE_HASHER_DEFINES_SVH

`ifndef SYNTHESIS
`define MTH_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("message_template_hasher: assertion failed");
`define MTH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("message_template_hasher: assertion failed");
`else
`define MTH_ASSERT_SAME(lbl, ante, cons)
`define MTH_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/mth_pkg.sv]
// constants and the fnv-1a round shared by the message template hasher
package mth_pkg;

    localparam logic [31:0] FNV_BASIS  = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME  = 32'd16777619;
    localparam logic [7:0]  ASCII_SPACE = 8'h20;
    localparam logic [7:0]  CASE_BIT    = 8'h20;
    localparam int          SENTINEL_LEN = 6;

    typedef logic [7:0] byte_t;

    localparam byte_t SENTINEL_TEXT [SENTINEL_LEN] = '{8'h5F, 8'h4E, 8'h4F, 8'h4D, 8'h53, 8'h47};

    function automatic logic [31:0] fnv_round(input logic [31:0] h, input byte_t b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        return x * FNV_PRIME;
    endfunction

    function automatic logic [31:0] sentinel_hash();
        logic [31:0] h;
        h = FNV_BASIS;
        for (int k = 0; k < SENTINEL_LEN; k++) begin
            h = fnv_round(h, SENTINEL_TEXT[k]);
        end
        return h;
    endfunction

    localparam logic [31:0] SENTINEL_HASH = sentinel_hash();

endpackage

[rtl/message_template_hasher.sv]
// message template hasher: word folding and fnv-1a 32 over one shared round unit
// each character is accepted in ST_IDLE, then ST_HASH runs one fnv round per hashed byte, up to three bytes
// a letter that completes a two-letter word hashes up to three bytes
// after its rounds finish, a last character waits in ST_OUT until the output register is free, then loads it
// the output register lets the next character in while a result waits to be taken
// reset (aresetn low, synchronous) clears the sequencer, word state and output valid
`include "message_template_hasher_defines.svh"

module message_template_hasher
    import mth_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic [0:0]  s_tuser,   // [0] has_byte
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] template_hash
    output logic [0:0]  m_tuser    // [0] no_words
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HASH = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    localparam logic [1:0] LEN_NONE = 2'd0;
    localparam logic [1:0] LEN_ONE  = 2'd1;
    localparam logic [1:0] LEN_MANY = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [31:0] hash_reg, hash_next;
    byte_t       pend_reg, pend_next;
    logic [1:0]  wlen_reg, wlen_next;
    logic        written_reg, written_next;
    logic        fin_reg, fin_next;
    logic [1:0]  cnt_reg, cnt_next;
    byte_t       queue_reg [3];
    byte_t       queue_next [3];
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_hash_reg, out_hash_next;
    logic        out_none_reg, out_none_next;

    logic        accept;
    logic        is_letter;
    byte_t       lc;
    logic        out_free;
    logic [31:0] round_out;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign is_letter = ((s_tdata >= 8'h41) && (s_tdata <= 8'h5A))
                    || ((s_tdata >= 8'h61) && (s_tdata <= 8'h7A));
    assign lc        = s_tdata | CASE_BIT;
    assign out_free  = !out_valid_reg || m_tready;
    assign round_out = fnv_round(hash_reg, queue_reg[0]);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_hash_reg;
    assign m_tuser  = out_none_reg;

    always_comb begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        pend_next      = pend_reg;
        wlen_next      = wlen_reg;
        written_next   = written_reg;
        fin_next       = fin_reg;
        cnt_next       = cnt_reg;
        queue_next     = queue_reg;
        out_valid_next = out_valid_reg;
        out_hash_next  = out_hash_reg;
        out_none_next  = out_none_reg;

        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    fin_next = s_tlast;
                    cnt_next = 2'd0;
                    if (s_tuser[0] && is_letter) begin
                        unique case (wlen_reg)
                            LEN_NONE: begin
                                pend_next = lc;
                                wlen_next = LEN_ONE;
                            end
                            LEN_ONE: begin
                                if (written_reg) begin
                                    queue_next[0] = ASCII_SPACE;
                                    queue_next[1] = pend_reg;
                                    queue_next[2] = lc;
                                    cnt_next      = 2'd3;
                                end else begin
                                    queue_next[0] = pend_reg;
                                    queue_next[1] = lc;
                                    cnt_next      = 2'd2;
                                end
                                written_next = 1'b1;
                                wlen_next    = LEN_MANY;
                            end
                            default: begin
                                queue_next[0] = lc;
                                cnt_next      = 2'd1;
                            end
                        endcase
                    end else if (s_tuser[0]) begin
                        wlen_next = LEN_NONE;
                    end
                    priority if (cnt_next != 2'd0) begin
                        state_next = ST_HASH;
                    end else if (s_tlast) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_HASH: begin
                hash_next     = round_out;
                queue_next[0] = queue_reg[1];
                queue_next[1] = queue_reg[2];
                cnt_next      = cnt_reg - 2'd1;
                if (cnt_reg == 2'd1) begin
                    state_next = fin_reg ? ST_OUT : ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_hash_next  = written_reg ? hash_reg : SENTINEL_HASH;
                    out_none_next  = !written_reg;
                    hash_next      = FNV_BASIS;
                    pend_next      = 8'd0;
                    wlen_next      = LEN_NONE;
                    written_next   = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            hash_reg      <= FNV_BASIS;
            pend_reg      <= 8'd0;
            wlen_reg      <= LEN_NONE;
            written_reg   <= 1'b0;
            fin_reg       <= 1'b0;
            cnt_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            pend_reg      <= pend_next;
            wlen_reg      <= wlen_next;
            written_reg   <= written_next;
            fin_reg       <= fin_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        queue_reg    <= queue_next;
        out_hash_reg <= out_hash_next;
        out_none_reg <= out_none_next;
    end

    // checks on the sequencer and word state
    `MTH_ASSERT_SAME(a_hash_has_work, state_reg == ST_HASH, cnt_reg != 2'd0)
    `MTH_ASSERT_SAME(a_wlen_range, 1'b1, wlen_reg != 2'd3)
    `MTH_ASSERT_SAME(a_unwritten_basis, !written_reg, hash_reg == FNV_BASIS)
    `MTH_ASSERT_NEXT(a_out_clears, (state_reg == ST_OUT) && out_free,
        (hash_reg == FNV_BASIS) && !written_reg && out_valid_reg)

endmodule
